[design/atsv_pkg.sv]
package atsv_pkg;

  localparam int unsigned StoreDepth = 14;
  localparam int unsigned CountSat = 16;
  localparam int unsigned UtcLen = 13;
  localparam int unsigned GenLen = 15;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharZ = 8'h5A;

  typedef enum logic [1:0] {
    KIND_INFER = 2'd0,
    KIND_UTC   = 2'd1,
    KIND_GEN   = 2'd2,
    KIND_BAD   = 2'd3
  } tag_kind_e;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_TAG      = 4'd1,
    ERR_LENGTH   = 4'd2,
    ERR_NO_Z     = 4'd3,
    ERR_NONDIGIT = 4'd4,
    ERR_YEAR     = 4'd5,
    ERR_MONTH    = 4'd6,
    ERR_DAY      = 4'd7,
    ERR_HOUR     = 4'd8,
    ERR_MINUTE   = 4'd9,
    ERR_SECOND   = 4'd10
  } error_code_e;

  typedef struct packed {
    logic [StoreDepth-1:0][3:0] digits;
    logic [4:0]                 len;
    logic [1:0]                 kind;
    logic                       last_z;
    logic                       nondigit;
  } job_t;

  function automatic logic [6:0] two_digit(logic [3:0] hi, logic [3:0] lo);
    return 7'(7'(hi) * 7'd10 + 7'(lo));
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] month);
    logic [4:0] days;
    case (month)
      4'd2:                     days = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  days = 5'd30;
      default:                  days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

[design/atsv_front.sv]
module atsv_front import atsv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       first_char_i,
  input  logic       last_char_i,
  input  logic [1:0] tag_kind_i,
  input  logic       q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [4:0] count_q, count_d, count_base, count_next;
  logic       nd_q, nd_d, nd_base;
  logic [3:0] store_q [StoreDepth];
  logic       accept, is_digit, store_en;
  logic [3:0] digit;

  assign in_stall_o = q_full_i;
  assign accept = in_valid_i && !q_full_i;
  assign is_digit = (char_code_i >= CharZero) && (char_code_i <= CharNine);
  assign digit = is_digit ? 4'(char_code_i - CharZero) : 4'd0;
  assign count_base = first_char_i ? 5'd0 : count_q;
  assign nd_base = first_char_i ? 1'b0 : nd_q;
  assign store_en = accept && (count_base < 5'(StoreDepth));
  assign count_next = (count_base < 5'(CountSat)) ? 5'(count_base + 5'd1) : count_base;

  always_comb begin
    count_d = count_q;
    nd_d = nd_q;
    if (accept) begin
      if (last_char_i) begin
        count_d = 5'd0;
        nd_d = 1'b0;
      end else begin
        count_d = count_next;
        nd_d = nd_base | !is_digit;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      job_o.digits[i] = (store_en && count_base == 5'(i)) ? digit : store_q[i];
    end
    job_o.len = count_next;
    job_o.kind = tag_kind_i;
    job_o.last_z = (char_code_i == CharZ);
    job_o.nondigit = nd_base;
  end

  assign push_o = accept && last_char_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 5'd0;
      nd_q <= 1'b0;
    end else begin
      count_q <= count_d;
      nd_q <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      store_q[count_base[3:0]] <= digit;
    end
  end

endmodule

[design/atsv_queue.sv]
module atsv_queue import atsv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic head_valid_o,
  output job_t head_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o = (cnt_q == CntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(wr_q + 1'b1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(rd_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

[design/atsv_back.sv]
module atsv_back import atsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  job_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  error_code_o,
  output logic        is_generalized_o,
  output logic [13:0] year_value_o,
  output logic [6:0]  month_value_o,
  output logic [6:0]  day_value_o,
  output logic [6:0]  hour_value_o,
  output logic [6:0]  minute_value_o,
  output logic [6:0]  second_value_o
);

  logic        valid_q;
  error_code_e err_q, err;
  logic        gen_q, gen;
  logic [13:0] year_q, year;
  logic [6:0]  month_q, day_q, hour_q, minute_q, second_q;
  logic [6:0]  p0, p2, month, day, hour, minute, second;
  logic        len_ok, leap;
  logic [4:0]  maxd;

  assign p0 = two_digit(head_i.digits[0], head_i.digits[1]);
  assign p2 = two_digit(head_i.digits[2], head_i.digits[3]);

  always_comb begin
    gen = (head_i.kind == KIND_GEN) ||
          (head_i.kind == KIND_INFER && head_i.len == 5'(GenLen));
    len_ok = gen ? (head_i.len == 5'(GenLen)) : (head_i.len == 5'(UtcLen));
    if (head_i.kind == KIND_BAD) begin
      gen = 1'b0;
    end
    if (gen) begin
      year = 14'(14'(p0) * 14'd100 + 14'(p2));
      month = two_digit(head_i.digits[4], head_i.digits[5]);
      day = two_digit(head_i.digits[6], head_i.digits[7]);
      hour = two_digit(head_i.digits[8], head_i.digits[9]);
      minute = two_digit(head_i.digits[10], head_i.digits[11]);
      second = two_digit(head_i.digits[12], head_i.digits[13]);
      leap = (p2[1:0] == 2'd0) && ((p2 != 7'd0) || (p0[1:0] == 2'd0));
    end else begin
      year = 14'(14'(p0) + ((p0 >= 7'd50) ? 14'd1900 : 14'd2000));
      month = p2;
      day = two_digit(head_i.digits[4], head_i.digits[5]);
      hour = two_digit(head_i.digits[6], head_i.digits[7]);
      minute = two_digit(head_i.digits[8], head_i.digits[9]);
      second = two_digit(head_i.digits[10], head_i.digits[11]);
      leap = (p0[1:0] == 2'd0);
    end
    maxd = (month == 7'd2 && leap) ? 5'd29 : month_days(month[3:0]);

    if (head_i.kind == KIND_BAD) begin
      err = ERR_TAG;
    end else if (!len_ok) begin
      err = ERR_LENGTH;
    end else if (!head_i.last_z) begin
      err = ERR_NO_Z;
    end else if (head_i.nondigit) begin
      err = ERR_NONDIGIT;
    end else if (year < 14'd1950 || year > (gen ? 14'd9999 : 14'd2049)) begin
      err = ERR_YEAR;
    end else if (month < 7'd1 || month > 7'd12) begin
      err = ERR_MONTH;
    end else if (day < 7'd1 || day > 7'(maxd)) begin
      err = ERR_DAY;
    end else if (hour > 7'd23) begin
      err = ERR_HOUR;
    end else if (minute > 7'd59) begin
      err = ERR_MINUTE;
    end else if (second > 7'd59) begin
      err = ERR_SECOND;
    end else begin
      err = ERR_NONE;
    end
  end

  assign pop_o = head_valid_i && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      err_q <= err;
      gen_q <= gen;
      if (err == ERR_NONE) begin
        year_q <= year;
        month_q <= month;
        day_q <= day;
        hour_q <= hour;
        minute_q <= minute;
        second_q <= second;
      end else begin
        year_q <= '0;
        month_q <= '0;
        day_q <= '0;
        hour_q <= '0;
        minute_q <= '0;
        second_q <= '0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign error_code_o = err_q;
  assign is_generalized_o = gen_q;
  assign year_value_o = year_q;
  assign month_value_o = month_q;
  assign day_value_o = day_q;
  assign hour_value_o = hour_q;
  assign minute_value_o = minute_q;
  assign second_value_o = second_q;

endmodule

[design/asn1_time_string_validator.sv]
// Checks ASN.1 UTCTime and GeneralizedTime strings given one character per
// input transaction. The input channel takes one character per cycle when not
// stalled, with its first and last marks and the tag kind, which is used on the
// last character. The output channel gives one transaction per string: an error
// code and the decoded year, month, day, hour, minute and second, which are zero
// on error. The front collects digits and, on the last character, writes a
// snapshot into a two-entry queue; the back validates the queue head
// combinationally into the output register. Throughput is one character per
// cycle when not stalled, set by the front; the back takes one string per
// cycle when the output is not stalled. If the receiver stalls, the output
// register holds its result and the queue fills; the input is stalled only
// while the queue is full. Reset clears the character count, the nondigit
// flag, the queue and the output valid; no result is pending after reset.
module asn1_time_string_validator import atsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        first_char_i,
  input  logic        last_char_i,
  input  logic [1:0]  tag_kind_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  error_code_o,
  output logic        is_generalized_o,
  output logic [13:0] year_value_o,
  output logic [6:0]  month_value_o,
  output logic [6:0]  day_value_o,
  output logic [6:0]  hour_value_o,
  output logic [6:0]  minute_value_o,
  output logic [6:0]  second_value_o
);

  logic q_full, push, head_valid, pop;
  job_t job, head;

  atsv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .first_char_i (first_char_i),
    .last_char_i  (last_char_i),
    .tag_kind_i   (tag_kind_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (job)
  );

  atsv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  atsv_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .error_code_o     (error_code_o),
    .is_generalized_o (is_generalized_o),
    .year_value_o     (year_value_o),
    .month_value_o    (month_value_o),
    .day_value_o      (day_value_o),
    .hour_value_o     (hour_value_o),
    .minute_value_o   (minute_value_o),
    .second_value_o   (second_value_o)
  );

endmodule

[tb/sv/asn1_time_string_validator_checker.sv]
`timescale 1ns / 100ps

module asn1_time_string_validator_checker import atsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  char_code_i,
  input  logic        first_char_i,
  input  logic        last_char_i,
  input  logic [1:0]  tag_kind_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  error_code_i,
  input  logic        is_generalized_i,
  input  logic [13:0] year_value_i,
  input  logic [6:0]  month_value_i,
  input  logic [6:0]  day_value_i,
  input  logic [6:0]  hour_value_i,
  input  logic [6:0]  minute_value_i,
  input  logic [6:0]  second_value_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [3:0]  err;
    logic        gen;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } time_fields_t;

  time_fields_t pending_times_q[$];
  logic [4:0]   char_count;
  logic [3:0]   digit_mem [StoreDepth];
  logic         nondigit_seen;

  function automatic int unsigned digit_pair(int unsigned pos);
    return int'(digit_mem[pos]) * 10 + int'(digit_mem[pos + 1]);
  endfunction

  function automatic int unsigned last_day_of(int unsigned year, int unsigned month);
    int unsigned days;
    bit          leap;
    leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    case (month)
      2: begin
        days = leap ? 29 : 28;
      end
      4, 6, 9, 11: begin
        days = 30;
      end
      default: begin
        days = 31;
      end
    endcase
    return days;
  endfunction

  // Digits are read only once the length matches the kind, so every position
  // read was written by the current string.
  function automatic time_fields_t decode_time(int unsigned len, logic [1:0] kind,
                                               logic [7:0] last_code);
    time_fields_t r;
    logic [1:0]   k;
    int unsigned  base;
    int unsigned  year;
    int unsigned  month;
    int unsigned  day;
    int unsigned  hour;
    int unsigned  minute;
    int unsigned  second;
    r = '0;
    k = kind;
    if (k == KIND_BAD) begin
      r.err = ERR_TAG;
      return r;
    end
    if (k == KIND_INFER) begin
      if (len == UtcLen) k = KIND_UTC;
      else if (len == GenLen) k = KIND_GEN;
      else begin
        r.err = ERR_LENGTH;
        return r;
      end
    end
    r.gen = (k == KIND_GEN);
    base = r.gen ? 4 : 2;
    if (len != (r.gen ? GenLen : UtcLen)) r.err = ERR_LENGTH;
    else if (last_code != CharZ) r.err = ERR_NO_Z;
    else if (nondigit_seen) r.err = ERR_NONDIGIT;
    else begin
      if (r.gen) year = digit_pair(0) * 100 + digit_pair(2);
      else year = digit_pair(0) + ((digit_pair(0) >= 50) ? 1900 : 2000);
      month  = digit_pair(base);
      day    = digit_pair(base + 2);
      hour   = digit_pair(base + 4);
      minute = digit_pair(base + 6);
      second = digit_pair(base + 8);
      if (year < 1950 || year > (r.gen ? 9999 : 2049)) r.err = ERR_YEAR;
      else if (month < 1 || month > 12) r.err = ERR_MONTH;
      else if (day < 1 || day > last_day_of(year, month)) r.err = ERR_DAY;
      else if (hour > 23) r.err = ERR_HOUR;
      else if (minute > 59) r.err = ERR_MINUTE;
      else if (second > 59) r.err = ERR_SECOND;
      else begin
        r.year   = 14'(year);
        r.month  = 7'(month);
        r.day    = 7'(day);
        r.hour   = 7'(hour);
        r.minute = 7'(minute);
        r.second = 7'(second);
      end
    end
    return r;
  endfunction

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    time_fields_t seen;
    time_fields_t want;
    logic         is_digit;
    if (!rst_ni) begin
      char_count = '0;
      nondigit_seen = 1'b0;
      pending_times_q.delete();
    end else begin
      // The result side is handled first so that a string finishing in this
      // cycle cannot be matched against an unexpected result.
      if (out_valid_i && !out_stall_i) begin
        seen = '{error_code_i, is_generalized_i, year_value_i, month_value_i, day_value_i,
                 hour_value_i, minute_value_i, second_value_i};
        if (pending_times_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, error_code %0d", $time, seen.err);
        end else begin
          want = pending_times_q.pop_front();
          if (seen !== want) begin
            fail_count_o++;
            $display("%0t: result mismatch, expected err %0d gen %0d %0d-%0d-%0d %0d:%0d:%0d",
                     $time, want.err, want.gen, want.year, want.month, want.day,
                     want.hour, want.minute, want.second);
            $display("%0t:                  actual   err %0d gen %0d %0d-%0d-%0d %0d:%0d:%0d",
                     $time, seen.err, seen.gen, seen.year, seen.month, seen.day,
                     seen.hour, seen.minute, seen.second);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        is_digit = (char_code_i >= CharZero) && (char_code_i <= CharNine);
        if (first_char_i) begin
          char_count = '0;
          nondigit_seen = 1'b0;
        end
        if (char_count < StoreDepth) begin
          digit_mem[char_count] = is_digit ? 4'(char_code_i - CharZero) : 4'd0;
        end
        if (!last_char_i && !is_digit) nondigit_seen = 1'b1;
        if (char_count < CountSat) char_count = char_count + 5'd1;
        if (last_char_i) begin
          pending_times_q.push_back(decode_time(char_count, tag_kind_i, char_code_i));
          char_count = '0;
          nondigit_seen = 1'b0;
        end
      end
    end
    pending_o = pending_times_q.size();
  end

endmodule

[tb/sv/asn1_time_string_validator_tb.sv]
`timescale 1ns / 100ps

module asn1_time_string_validator_tb;
  import atsv_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned RandomChars = 900;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = '0;
  logic        first_char = 1'b0;
  logic        last_char = 1'b0;
  logic [1:0]  tag_kind = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  error_code;
  logic        is_generalized;
  logic [13:0] year_value;
  logic [6:0]  month_value;
  logic [6:0]  day_value;
  logic [6:0]  hour_value;
  logic [6:0]  minute_value;
  logic [6:0]  second_value;
  int          fail_count;
  int          pending;

  logic [7:0]  text_q[$];
  int unsigned sent_chars = 0;
  int unsigned cycle_count = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  asn1_time_string_validator u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .char_code_i      (char_code),
    .first_char_i     (first_char),
    .last_char_i      (last_char),
    .tag_kind_i       (tag_kind),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .error_code_o     (error_code),
    .is_generalized_o (is_generalized),
    .year_value_o     (year_value),
    .month_value_o    (month_value),
    .day_value_o      (day_value),
    .hour_value_o     (hour_value),
    .minute_value_o   (minute_value),
    .second_value_o   (second_value)
  );

  asn1_time_string_validator_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .char_code_i      (char_code),
    .first_char_i     (first_char),
    .last_char_i      (last_char),
    .tag_kind_i       (tag_kind),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .error_code_i     (error_code),
    .is_generalized_i (is_generalized),
    .year_value_i     (year_value),
    .month_value_i    (month_value),
    .day_value_i      (day_value),
    .hour_value_i     (hour_value),
    .minute_value_i   (minute_value),
    .second_value_i   (second_value),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // Stall is sampled at the falling edge, where it already holds the value
  // seen at the next rising edge.
  task automatic send_char(input logic [7:0] code, input logic mark_first,
                           input logic mark_last, input logic [1:0] kind);
    int unsigned gap;
    logic        stalled;
    if ($urandom_range(0, 39) == 0) in_calm = ($urandom_range(0, 2) == 0);
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    char_code  <= code;
    first_char <= mark_first;
    last_char  <= mark_last;
    tag_kind   <= kind;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sent_chars++;
  endtask

  task automatic send_text(input bit mark_first, input logic [1:0] kind);
    int unsigned n;
    n = text_q.size();
    for (int i = 0; i < n; i++) begin
      send_char(text_q[i], mark_first && (i == 0), i == n - 1,
                (i == n - 1) ? kind : 2'($urandom_range(0, 3)));
    end
  endtask

  task automatic put_number(input int unsigned value, input int unsigned ndigits);
    int unsigned scale;
    scale = 1;
    repeat (ndigits - 1) scale = scale * 10;
    repeat (ndigits) begin
      text_q.push_back(8'(CharZero + (value / scale) % 10));
      scale = scale / 10;
    end
  endtask

  task automatic build_time(input bit gen, input int unsigned year, input int unsigned month,
                            input int unsigned day, input int unsigned hour,
                            input int unsigned minute, input int unsigned second);
    text_q.delete();
    put_number(year, gen ? 4 : 2);
    put_number(month, 2);
    put_number(day, 2);
    put_number(hour, 2);
    put_number(minute, 2);
    put_number(second, 2);
    text_q.push_back(CharZ);
  endtask

  task automatic send_noise();
    int unsigned len;
    int unsigned pick;
    logic [7:0]  code;
    len = $urandom_range(1, 20);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 5);
      if (pick < 3) code = 8'(CharZero + $urandom_range(0, 9));
      else if (pick == 3) code = CharZ;
      else code = 8'($urandom_range(0, 255));
      send_char(code, $urandom_range(0, 9) == 0, (i == len - 1) && ($urandom_range(0, 9) != 0),
                2'($urandom_range(0, 3)));
    end
  endtask

  task automatic send_random_time();
    bit          gen;
    int unsigned year;
    int unsigned month;
    int unsigned day;
    int unsigned hour;
    int unsigned minute;
    int unsigned second;
    int unsigned pick;
    logic [1:0]  kind;
    gen = 1'($urandom_range(0, 1));
    if (!gen) year = $urandom_range(0, 99);
    else if ($urandom_range(0, 9) == 0) year = $urandom_range(0, 9999);
    else year = $urandom_range(1950, 9999);
    if ($urandom_range(0, 19) == 0) month = $urandom_range(0, 99);
    else month = $urandom_range(1, 12);
    pick = $urandom_range(0, 9);
    if (pick < 5) day = $urandom_range(1, 28);
    else if (pick < 9) day = $urandom_range(28, 31);
    else day = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) hour = $urandom_range(0, 99);
    else hour = $urandom_range(0, 23);
    if ($urandom_range(0, 9) == 0) minute = $urandom_range(0, 99);
    else minute = $urandom_range(0, 59);
    if ($urandom_range(0, 9) == 0) second = $urandom_range(58, 99);
    else second = $urandom_range(0, 59);
    build_time(gen, year, month, day, hour, minute, second);
    pick = $urandom_range(0, 19);
    if (pick == 0) text_q[text_q.size() - 1] = 8'($urandom_range(0, 255));
    else if (pick == 1) text_q[$urandom_range(0, text_q.size() - 2)] = 8'($urandom_range(0, 255));
    else if (pick == 2) text_q.push_front(8'(CharZero + $urandom_range(0, 9)));
    else if (pick == 3) void'(text_q.pop_front());
    pick = $urandom_range(0, 9);
    if (pick < 5) kind = KIND_INFER;
    else if (pick < 8) kind = gen ? KIND_GEN : KIND_UTC;
    else if (pick == 8) kind = gen ? KIND_UTC : KIND_GEN;
    else kind = KIND_BAD;
    send_text($urandom_range(0, 7) != 0, kind);
  endtask

  initial begin : result_sink
    int unsigned hold;
    logic        offered;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = ($urandom_range(0, 2) == 0);
      hold = draw_wait(out_calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        offered = out_valid;
        @(posedge clk);
      end while (!offered);
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_time(0, 50, 1, 1, 0, 0, 0);
    send_text(1, KIND_INFER);
    build_time(0, 49, 12, 31, 23, 59, 59);
    send_text(1, KIND_UTC);
    build_time(1, 9999, 12, 31, 23, 59, 59);
    send_text(1, KIND_GEN);
    build_time(1, 1949, 12, 31, 23, 59, 59);
    send_text(1, KIND_INFER);
    build_time(1, 0, 1, 1, 0, 0, 0);
    send_text(1, KIND_GEN);
    build_time(1, 2000, 2, 29, 12, 0, 0);
    send_text(1, KIND_INFER);
    build_time(1, 2100, 2, 29, 12, 0, 0);
    send_text(1, KIND_GEN);
    build_time(0, 24, 2, 29, 0, 0, 0);
    send_text(1, KIND_UTC);
    build_time(0, 23, 2, 29, 0, 0, 0);
    send_text(1, KIND_INFER);
    build_time(1, 2024, 0, 10, 0, 0, 0);
    send_text(1, KIND_INFER);
    build_time(1, 2024, 13, 10, 0, 0, 0);
    send_text(1, KIND_INFER);
    build_time(0, 99, 4, 31, 0, 0, 0);
    send_text(1, KIND_INFER);
    build_time(0, 99, 1, 0, 0, 0, 0);
    send_text(1, KIND_INFER);
    build_time(0, 10, 5, 5, 24, 0, 0);
    send_text(1, KIND_INFER);
    build_time(0, 10, 5, 5, 0, 60, 0);
    send_text(1, KIND_INFER);
    build_time(0, 10, 5, 5, 0, 0, 60);
    send_text(1, KIND_INFER);
    build_time(0, 10, 5, 5, 1, 2, 3);
    send_text(1, KIND_BAD);
    build_time(0, 10, 5, 5, 1, 2, 3);
    send_text(1, KIND_GEN);
    build_time(1, 2010, 5, 5, 1, 2, 3);
    send_text(1, KIND_UTC);
    build_time(0, 10, 5, 5, 1, 2, 3);
    text_q[text_q.size() - 1] = 8'hFF;
    send_text(1, KIND_INFER);
    build_time(0, 10, 5, 5, 1, 2, 3);
    text_q[3] = 8'h00;
    text_q[7] = 8'h3A;
    send_text(1, KIND_INFER);
    build_time(1, 2010, 5, 5, 1, 2, 3);
    text_q[0] = 8'h2F;
    send_text(1, KIND_GEN);

    // An overlong string saturates the count.
    build_time(1, 2010, 5, 5, 1, 2, 3);
    repeat (5) text_q.push_front(CharNine);
    send_text(1, KIND_INFER);

    text_q.delete();
    text_q.push_back(CharZ);
    send_text(1, KIND_INFER);
    send_text(1, KIND_BAD);

    build_time(0, 77, 7, 7, 7, 7, 7);
    send_text(0, KIND_UTC);

    // A first mark in mid-string discards what was collected before it.
    send_char(CharNine, 1'b1, 1'b0, KIND_GEN);
    repeat (4) send_char(8'h41, 1'b0, 1'b0, KIND_GEN);
    build_time(1, 1987, 6, 30, 18, 45, 9);
    send_text(1, KIND_INFER);

    while (sent_chars < RandomChars) begin
      if ($urandom_range(0, 3) == 0) send_noise();
      else send_random_time();
    end
    send_random_time();
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/atsv_pkg.sv
design/atsv_front.sv
design/atsv_queue.sv
design/atsv_back.sv
design/asn1_time_string_validator.sv
tb/sv/asn1_time_string_validator_checker.sv
tb/sv/asn1_time_string_validator_tb.sv
